// File: rtl/core/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/dspm_pkg.sv
package dspm_pkg;

   localparam int MAX_ELEMENTS = 32;
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int IDX_W = $clog2(MAX_ELEMENTS);

   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] DOT_BYTE = 8'h2E;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_TEXT   = 2'd2,
      MODE_END    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_STORE,
      OP_MARK,
      OP_TEXT,
      OP_END
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       symbol;
      logic [CNT_W-1:0] count;
   } ctrl_type;

   typedef struct packed {
      logic carry;
      logic adv;
   } link_type;

   typedef struct packed {
      logic alive;
      logic starred;
      logic active;
   } cell_status_type;

endpackage

// File: rtl/core/dspm_if.sv
interface dspm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] symbol;

   modport source (output valid, output mode, output symbol, input ready);
   modport sink (input valid, input mode, input symbol, output ready);
endinterface

interface dspm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic overflowed;

   modport source (output valid, output matched, output overflowed, input ready);
   modport sink (input valid, input matched, input overflowed, output ready);
endinterface

// File: rtl/core/dot_star_pattern_matcher_core.sv
// Whole-string matcher for patterns of literal bytes, '.' (any byte) and '*' (repeat the
// element before it). Mode 0 clears the pattern, mode 1 appends a pattern byte, mode 2
// feeds a text byte, mode 3 ends the text and returns one item with matched and
// overflowed, then restarts the text while keeping the pattern. The block accepts one
// item per cycle as long as results are taken; the critical path is the closure ripple
// across the row of element cells (one cell per pattern element, MAX_ELEMENTS cells).
// Results leave through a single output register; a new item is accepted while that
// register is empty or being drained. Appending more than MAX_ELEMENTS elements sets a
// sticky overflow that forces matched to zero until the next clear.
`include "assert_macros.svh"

module dot_star_pattern_matcher_core
   import dspm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   dspm_req_if.sink   req_chan,
   dspm_rsp_if.source rsp_chan
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             active_last_ff, active_last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             overflowed_ff, overflowed_in;

   ctrl_type         ctrl;
   link_type         link [MAX_ELEMENTS+1];
   cell_status_type  status [MAX_ELEMENTS];

   logic [MAX_ELEMENTS:0]   alive_vec;
   logic [MAX_ELEMENTS:0]   active_vec;
   logic [MAX_ELEMENTS-1:0] starred_vec;
   logic [CNT_W-1:0]        prev_count;
   logic                    accept;
   logic                    prev_starred;
   mode_type                mode;

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;
   assign mode           = mode_type'(req_chan.mode);
   assign prev_count     = count_ff - CNT_W'(1);
   assign prev_starred   = starred_vec[prev_count[IDX_W-1:0]];

   assign link[0] = '0;

   for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
      dspm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(g)),
         .ctrl      (ctrl),
         .prev_link (link[g]),
         .next_link (link[g+1]),
         .status    (status[g])
      );
      assign alive_vec[g]   = status[g].alive;
      assign active_vec[g]  = status[g].active;
      assign starred_vec[g] = status[g].starred;
   end

   assign alive_vec[MAX_ELEMENTS]  = active_last_ff | link[MAX_ELEMENTS].carry;
   assign active_vec[MAX_ELEMENTS] = active_last_ff;

   // decode the accepted item into a row command
   always_comb begin
      ctrl.op     = OP_NONE;
      ctrl.symbol = req_chan.symbol;
      ctrl.count  = count_ff;
      ovf_in      = ovf_ff;
      count_in    = count_ff;
      if (accept) begin
         case (mode)
            MODE_CLEAR: begin
               ctrl.op  = OP_CLEAR;
               ovf_in   = 1'b0;
               count_in = '0;
            end
            MODE_APPEND: begin
               if (req_chan.symbol == STAR_BYTE && count_ff != '0 && !prev_starred) begin
                  ctrl.op = OP_MARK;
               end else if (count_ff == CNT_W'(MAX_ELEMENTS)) begin
                  ovf_in = 1'b1;
               end else begin
                  ctrl.op  = OP_STORE;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            MODE_TEXT: ctrl.op = OP_TEXT;
            MODE_END:  ctrl.op = OP_END;
            default:   ctrl.op = OP_NONE;
         endcase
      end
   end

   always_comb begin
      case (ctrl.op)
         OP_TEXT:           active_last_in = link[MAX_ELEMENTS].adv;
         OP_CLEAR, OP_END:  active_last_in = 1'b0;
         default:           active_last_in = active_last_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      matched_in    = matched_ff;
      overflowed_in = overflowed_ff;
      if (ctrl.op == OP_END) begin
         rsp_valid_in  = 1'b1;
         matched_in    = alive_vec[count_ff] & ~ovf_ff;
         overflowed_in = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         active_last_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         ovf_ff         <= ovf_in;
         active_last_ff <= active_last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff    <= matched_in;
      overflowed_ff <= overflowed_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.matched    = matched_ff;
   assign rsp_chan.overflowed = overflowed_ff;

   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ELEMENTS))
   `ASSERT_SAME(a_no_active_past_end, clock, reset, 1'b1, (active_vec >> count_ff) <= (MAX_ELEMENTS+1)'(1))
   `ASSERT_SAME(a_ovf_no_match, clock, reset, rsp_valid_ff && overflowed_ff, !matched_ff)
   `ASSERT_NEXT(a_end_restarts, clock, reset, accept && mode == MODE_END,
                active_vec == (MAX_ELEMENTS+1)'(1))

endmodule

// File: rtl/core/dspm_cell.sv
module dspm_cell
   import dspm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  ctrl_type         ctrl,
   input  link_type         prev_link,
   output link_type         next_link,
   output cell_status_type  status
);

   logic [7:0] byte_ff, byte_in;
   logic       used_ff, used_in;
   logic       starred_ff, starred_in;
   logic       active_ff, active_in;

   logic             alive;
   logic             match;
   logic [CNT_W-1:0] idx_ext;
   logic             sel_store;
   logic             sel_mark;
   logic             is_first;

   assign idx_ext   = CNT_W'(cell_idx);
   assign sel_store = (idx_ext == ctrl.count);
   assign sel_mark  = ((idx_ext + CNT_W'(1)) == ctrl.count);
   assign is_first  = (cell_idx == '0);

   assign alive = active_ff | prev_link.carry;
   assign match = alive & used_ff & ((byte_ff == DOT_BYTE) || (byte_ff == ctrl.symbol));

   assign next_link.carry = alive & starred_ff;
   assign next_link.adv   = match & ~starred_ff;

   assign status.alive   = alive;
   assign status.starred = starred_ff;
   assign status.active  = active_ff;

   always_comb begin
      byte_in    = byte_ff;
      used_in    = used_ff;
      starred_in = starred_ff;
      active_in  = active_ff;
      case (ctrl.op)
         OP_CLEAR: begin
            used_in    = 1'b0;
            starred_in = 1'b0;
            active_in  = is_first;
         end
         OP_STORE: begin
            if (sel_store) begin
               byte_in    = ctrl.symbol;
               used_in    = 1'b1;
               starred_in = 1'b0;
            end
         end
         OP_MARK: begin
            if (sel_mark) begin
               starred_in = 1'b1;
            end
         end
         OP_TEXT: begin
            active_in = (match & starred_ff) | prev_link.adv;
         end
         OP_END: begin
            active_in = is_first;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= 1'b0;
         starred_ff <= 1'b0;
         active_ff  <= is_first;
      end else begin
         used_ff    <= used_in;
         starred_ff <= starred_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// File: dv/dspm_score_pkg.sv
`timescale 1ns / 1ps

package dspm_score_pkg;
   import dspm_pkg::*;

   typedef struct packed {
      logic matched;
      logic overflowed;
   } verdict_type;

   class dspm_scoreboard;
      logic [7:0] elem_byte [MAX_ELEMENTS];
      bit elem_star [MAX_ELEMENTS];
      int unsigned elem_cnt;
      bit [MAX_ELEMENTS:0] live;
      bit overflow;
      verdict_type verdict_q [$];
      int errors;

      function new();
         foreach (elem_byte[i]) begin
            elem_byte[i] = 8'h00;
            elem_star[i] = 1'b0;
         end
         elem_cnt = 0;
         live = 1;
         overflow = 1'b0;
         errors = 0;
      endfunction

      // starred positions can be skipped without consuming a byte
      function bit [MAX_ELEMENTS:0] close_over_stars(bit [MAX_ELEMENTS:0] set);
         for (int p = 0; p < elem_cnt; p++) begin
            if (set[p] && elem_star[p]) set[p + 1] = 1'b1;
         end
         return set;
      endfunction

      function void note_item(mode_type mode, logic [7:0] symbol);
         bit [MAX_ELEMENTS:0] alive;
         bit [MAX_ELEMENTS:0] nxt;
         verdict_type v;
         case (mode)
            MODE_CLEAR: begin
               foreach (elem_star[i]) elem_star[i] = 1'b0;
               elem_cnt = 0;
               overflow = 1'b0;
               live = 1;
            end
            MODE_APPEND: begin
               if (symbol == STAR_BYTE && elem_cnt > 0 && !elem_star[elem_cnt - 1]) begin
                  elem_star[elem_cnt - 1] = 1'b1;
               end else if (elem_cnt >= MAX_ELEMENTS) begin
                  overflow = 1'b1;
               end else begin
                  elem_byte[elem_cnt] = symbol;
                  elem_star[elem_cnt] = 1'b0;
                  elem_cnt++;
               end
            end
            MODE_TEXT: begin
               alive = close_over_stars(live);
               nxt = '0;
               for (int p = 0; p < elem_cnt; p++) begin
                  if (alive[p] && (elem_byte[p] == DOT_BYTE || elem_byte[p] == symbol)) begin
                     if (elem_star[p]) nxt[p] = 1'b1;
                     else nxt[p + 1] = 1'b1;
                  end
               end
               live = nxt;
            end
            default: begin
               alive = close_over_stars(live);
               v.matched = alive[elem_cnt] && !overflow;
               v.overflowed = overflow;
               verdict_q.push_back(v);
               live = 1;
            end
         endcase
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic matched, logic overflowed);
         verdict_type want;
         if (verdict_q.size() == 0) begin
            report($sformatf("result matched=%0b overflowed=%0b with nothing expected",
                             matched, overflowed));
            return;
         end
         want = verdict_q.pop_front();
         if (matched !== want.matched)
            report($sformatf("matched %0b, want %0b", matched, want.matched));
         if (overflowed !== want.overflowed)
            report($sformatf("overflowed %0b, want %0b", overflowed, want.overflowed));
      endtask

      task flag_leftovers();
         if (verdict_q.size() != 0)
            report($sformatf("%0d results never arrived", verdict_q.size()));
      endtask

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

endpackage

// File: dv/dot_star_pattern_matcher_core_test.sv
`timescale 1ns / 1ps

module dot_star_pattern_matcher_core_test;
   import dspm_pkg::*;
   import dspm_score_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int PHASE_ITEMS = 420;
   localparam logic [7:0] LETTER_A = 8'h61;
   localparam logic [7:0] LETTER_B = 8'h62;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int sent_items = 0;
   int quiet_cycles = 0;
   dspm_scoreboard sb = new();

   dspm_req_if req_chan ();
   dspm_rsp_if rsp_chan ();

   dot_star_pattern_matcher_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // older results first, then the item that arrives at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.matched, rsp_chan.overflowed);
         if (req_chan.valid && req_chan.ready)
            sb.note_item(mode_type'(req_chan.mode), req_chan.symbol);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return LETTER_A;
      if (r < 60) return LETTER_B;
      if (r < 75) return DOT_BYTE;
      if (r < 90) return STAR_BYTE;
      return 8'($urandom);
   endfunction

   task automatic send_item(mode_type mode, logic [7:0] symbol);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.symbol <= symbol;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // one pattern, then one to four texts against it, or else a short run of random items
   task automatic run_sequence();
      logic [7:0] pat_byte [$];
      bit pat_star [$];
      logic [7:0] txt [$];
      int n_el;
      int reps;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 6))
            send_item(mode_type'($urandom_range(0, 3)), 8'($urandom));
         return;
      end
      if ($urandom_range(0, 9) != 0) send_item(MODE_CLEAR, 8'($urandom));
      n_el = ($urandom_range(0, 14) == 0) ?
             $urandom_range(MAX_ELEMENTS - 3, MAX_ELEMENTS + 4) : $urandom_range(0, 7);
      for (int i = 0; i < n_el; i++) begin
         pat_byte.push_back(pick_byte());
         pat_star.push_back($urandom_range(0, 2) == 0);
         send_item(MODE_APPEND, pat_byte[i]);
         if (pat_star[i]) send_item(MODE_APPEND, STAR_BYTE);
      end
      if ($urandom_range(0, 9) == 0) send_item(MODE_APPEND, STAR_BYTE);
      repeat ($urandom_range(1, 4)) begin
         txt.delete();
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(0, 6)) txt.push_back(pick_byte());
         end else begin
            foreach (pat_byte[i]) begin
               reps = pat_star[i] ? $urandom_range(0, 2) : 1;
               repeat (reps)
                  txt.push_back((pat_byte[i] == DOT_BYTE) ? 8'($urandom) : pat_byte[i]);
            end
            if (txt.size() > 0 && $urandom_range(0, 3) == 0)
               txt[$urandom_range(0, txt.size() - 1)] = pick_byte();
         end
         foreach (txt[i]) begin
            if ($urandom_range(0, 39) == 0) send_item(MODE_APPEND, pick_byte());
            send_item(MODE_TEXT, txt[i]);
         end
         send_item(MODE_END, 8'($urandom));
      end
   endtask

   initial begin
      int goal;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_CLEAR;
      req_chan.symbol = 8'h00;
      rsp_chan.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty pattern against empty and one-byte text
      send_item(MODE_CLEAR, 8'hFF);
      send_item(MODE_END, 8'h00);
      send_item(MODE_TEXT, LETTER_A);
      send_item(MODE_END, 8'hFF);
      // leading star is a literal, a second star then repeats it
      send_item(MODE_APPEND, STAR_BYTE);
      send_item(MODE_TEXT, STAR_BYTE);
      send_item(MODE_END, 8'h00);
      send_item(MODE_APPEND, STAR_BYTE);
      send_item(MODE_END, 8'h00);
      // dot star followed by extreme byte values
      send_item(MODE_CLEAR, 8'h00);
      send_item(MODE_APPEND, DOT_BYTE);
      send_item(MODE_APPEND, STAR_BYTE);
      send_item(MODE_APPEND, 8'hFF);
      send_item(MODE_APPEND, 8'h00);
      send_item(MODE_TEXT, 8'h7F);
      send_item(MODE_TEXT, 8'hFF);
      send_item(MODE_TEXT, 8'h00);
      send_item(MODE_END, 8'hFF);
      // star after a starred element is a literal
      send_item(MODE_APPEND, STAR_BYTE);
      send_item(MODE_APPEND, STAR_BYTE);
      send_item(MODE_TEXT, 8'hFF);
      send_item(MODE_TEXT, STAR_BYTE);
      send_item(MODE_END, 8'h00);
      send_item(MODE_CLEAR, 8'h00);
      send_item(MODE_END, 8'h00);

      for (int ph = 0; ph < 3; ph++) begin
         hold_until_drained();
         send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 59 : 0;
         rsp_stall_pct = (ph == 0) ? 59 : (ph == 1) ? 24 : 0;
         goal = sent_items + PHASE_ITEMS;
         while (sent_items < goal) run_sequence();
      end

      hold_until_drained();
      repeat (16) @(posedge clock);
      sb.flag_leftovers();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dspm_pkg.sv
rtl/core/dspm_if.sv
rtl/core/dspm_cell.sv
rtl/core/dot_star_pattern_matcher_core.sv
dv/dspm_score_pkg.sv
dv/dot_star_pattern_matcher_core_test.sv
